### design/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

	// Pipeline depth and the role of each stage.
	localparam int NUM_STAGES = 9;
	localparam int STG_DT     = 0;
	localparam int STG_MUL    = 1;
	localparam int STG_SHIFT  = 2;
	localparam int STG_SQ     = 3;
	localparam int STG_CORR   = 4;
	localparam int STG_SUB    = 5;
	localparam int STG_PART   = 6;
	localparam int STG_SUM    = 7;
	localparam int STG_OUT    = 8;

	// Calibration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SENSITIVITY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY_TEMP_COEFF = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEFF      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_TEMPERATURE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE_COEFF      = 3'd5;

	// Reference temperature of 20.00 degrees, and the distance from it down to -15.00 degrees.
	localparam logic signed [18:0] TEMP_REF    = 19'sd2000;
	localparam logic signed [18:0] LOW_MARGIN  = 19'sd3500;
	localparam logic signed [17:0] LOW_DELTA   = -18'sd3500;

	typedef struct packed {
		logic [23:0] raw_pressure;
		logic [23:0] raw_temperature;
	} in_word_t;

	typedef struct packed {
		logic signed [18:0] temperature;
		logic signed [31:0] pressure;
	} out_word_t;

	typedef struct packed {
		logic [15:0] pressure_sensitivity;
		logic [15:0] pressure_offset;
		logic [15:0] sensitivity_temp_coeff;
		logic [15:0] offset_temp_coeff;
		logic [15:0] reference_temperature;
		logic [15:0] temperature_coeff;
	} cal_t;

	// Per-stage load enables from the pipeline control.
	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
	} ctl_t;

	// Word handed from the compensation stages to the pressure stages.
	typedef struct packed {
		logic [23:0]        raw_pressure;
		logic signed [18:0] temperature;
		logic [39:0]        offset;
		logic [39:0]        sensitivity;
	} mid_t;

endpackage

`default_nettype wire

### design/bpc_cfg.sv
`default_nettype none

module bpc_cfg
	import bpc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data,
	output cal_t                      cal
);

	cal_t cal_q;

	// Writes are always taken; an index past the last register is dropped.
	assign cfg_ready = 1'b1;
	assign cal       = cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PRESSURE_SENSITIVITY:   cal_q.pressure_sensitivity   <= cfg_data;
				REG_PRESSURE_OFFSET:        cal_q.pressure_offset        <= cfg_data;
				REG_SENSITIVITY_TEMP_COEFF: cal_q.sensitivity_temp_coeff <= cfg_data;
				REG_OFFSET_TEMP_COEFF:      cal_q.offset_temp_coeff      <= cfg_data;
				REG_REFERENCE_TEMPERATURE:  cal_q.reference_temperature  <= cfg_data;
				REG_TEMPERATURE_COEFF:      cal_q.temperature_coeff      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### design/bpc_ctrl.sv
`default_nettype none

module bpc_ctrl
	import bpc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output ctl_t      ctl
);

	logic [NUM_STAGES-1:0] vld_q;

	// A stage may load when it is empty or when the stage after it loads too,
	// so bubbles close up while the output is stalled.
	always_comb begin
		ctl.en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			ctl.en[k] = !vld_q[k] || ctl.en[k+1];
		end
	end

	assign in_ready  = ctl.en[STG_DT];
	assign out_valid = vld_q[STG_OUT];

	// Valid bits move along with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ctl.en[STG_DT]) begin
				vld_q[STG_DT] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (ctl.en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

endmodule

`default_nettype wire

### design/bpc_core.sv
`default_nettype none

module bpc_core
	import bpc_pkg::*;
(
	input  wire logic     clk,
	input  wire cal_t     cal,
	input  wire ctl_t     ctl,
	input  wire in_word_t in_data,
	output mid_t          mid
);

	// Stage 1: temperature difference against the reference.
	logic [23:0]        d1_s1;
	logic signed [24:0] dt_s1;

	always_ff @(posedge clk) begin
		if (ctl.en[STG_DT]) begin
			d1_s1 <= in_data.raw_pressure;
			dt_s1 <= $signed({1'b0, in_data.raw_temperature}
				- {1'b0, cal.reference_temperature, 8'h00});
		end
	end

	// Stage 2: the three calibration products and the square of the difference.
	logic [23:0]        d1_s2;
	logic signed [41:0] p6_s2;
	logic signed [41:0] p4_s2;
	logic signed [41:0] p3_s2;
	logic signed [49:0] dsq_s2;

	always_ff @(posedge clk) begin
		if (ctl.en[STG_MUL]) begin
			d1_s2  <= d1_s1;
			p6_s2  <= dt_s1 * $signed({1'b0, cal.temperature_coeff});
			p4_s2  <= dt_s1 * $signed({1'b0, cal.offset_temp_coeff});
			p3_s2  <= dt_s1 * $signed({1'b0, cal.sensitivity_temp_coeff});
			dsq_s2 <= dt_s1 * dt_s1;
		end
	end

	// Stage 3: first-order temperature, offset and sensitivity.
	// The products stay below 2^40 in magnitude, so the shifts are plain slices.
	logic signed [17:0] x_c;
	logic signed [18:0] x2_c;
	logic [18:0]        temp_c;
	logic [35:0]        off_c;
	logic [34:0]        sens_c;

	assign x_c    = p6_s2[40:23];
	assign x2_c   = {x_c[17], x_c} + LOW_MARGIN;
	assign temp_c = {x_c[17], x_c} + TEMP_REF;
	assign off_c  = {4'b0000, cal.pressure_offset, 16'h0000}
		+ {{2{p4_s2[40]}}, p4_s2[40:7]};
	assign sens_c = {4'b0000, cal.pressure_sensitivity, 15'h0000}
		+ {{2{p3_s2[40]}}, p3_s2[40:8]};

	logic [23:0]        d1_s3;
	logic signed [17:0] x_s3;
	logic signed [18:0] x2_s3;
	logic [18:0]        temp_s3;
	logic [35:0]        off_s3;
	logic [34:0]        sens_s3;
	logic [16:0]        t2_s3;
	logic               cold_s3;
	logic               frigid_s3;

	always_ff @(posedge clk) begin
		if (ctl.en[STG_SHIFT]) begin
			d1_s3     <= d1_s2;
			x_s3      <= x_c;
			x2_s3     <= x2_c;
			temp_s3   <= temp_c;
			off_s3    <= off_c;
			sens_s3   <= sens_c;
			t2_s3     <= dsq_s2[47:31];
			cold_s3   <= x_c[17];
			frigid_s3 <= x_c < LOW_DELTA;
		end
	end

	// Stage 4: squared distances below 20 and below -15 degrees; final temperature.
	logic signed [35:0] sq1_c;
	logic signed [37:0] sq2_c;

	assign sq1_c = x_s3 * x_s3;
	assign sq2_c = x2_s3 * x2_s3;

	logic [23:0] d1_s4;
	logic [34:0] sq1_s4;
	logic [34:0] sq2_s4;
	logic [18:0] tout_s4;
	logic [35:0] off_s4;
	logic [34:0] sens_s4;
	logic        cold_s4;
	logic        frigid_s4;

	always_ff @(posedge clk) begin
		if (ctl.en[STG_SQ]) begin
			d1_s4     <= d1_s3;
			sq1_s4    <= sq1_c[34:0];
			sq2_s4    <= sq2_c[34:0];
			tout_s4   <= temp_s3 - (cold_s3 ? {2'b00, t2_s3} : 19'd0);
			off_s4    <= off_s3;
			sens_s4   <= sens_s3;
			cold_s4   <= cold_s3;
			frigid_s4 <= frigid_s3;
		end
	end

	// Stage 5: second-order offset and sensitivity corrections.
	logic [36:0] m5_c;
	logic [37:0] m7_c;
	logic [37:0] m11_c;
	logic [37:0] off2_c;
	logic [37:0] sens2_c;

	assign m5_c  = {sq1_s4, 2'b00} + {2'b00, sq1_s4};
	assign m7_c  = {sq2_s4, 3'b000} - {3'b000, sq2_s4};
	assign m11_c = {sq2_s4, 3'b000} + {2'b00, sq2_s4, 1'b0} + {3'b000, sq2_s4};

	always_comb begin
		off2_c  = '0;
		sens2_c = '0;
		if (cold_s4) begin
			off2_c  = {2'b00, m5_c[36:1]} + (frigid_s4 ? m7_c : 38'd0);
			sens2_c = {3'b000, m5_c[36:2]} + (frigid_s4 ? {1'b0, m11_c[37:1]} : 38'd0);
		end
	end

	logic [23:0] d1_s5;
	logic [18:0] tout_s5;
	logic [35:0] off_s5;
	logic [34:0] sens_s5;
	logic [37:0] off2_s5;
	logic [37:0] sens2_s5;

	always_ff @(posedge clk) begin
		if (ctl.en[STG_CORR]) begin
			d1_s5    <= d1_s4;
			tout_s5  <= tout_s4;
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			off2_s5  <= off2_c;
			sens2_s5 <= sens2_c;
		end
	end

	// Stage 6: corrected offset and sensitivity.
	mid_t mid_s6;

	always_ff @(posedge clk) begin
		if (ctl.en[STG_SUB]) begin
			mid_s6.raw_pressure <= d1_s5;
			mid_s6.temperature  <= tout_s5;
			mid_s6.offset       <= {{4{off_s5[35]}}, off_s5} - {2'b00, off2_s5};
			mid_s6.sensitivity  <= {{5{sens_s5[34]}}, sens_s5} - {2'b00, sens2_s5};
		end
	end

	assign mid = mid_s6;

endmodule

`default_nettype wire

### design/bpc_press.sv
`default_nettype none

module bpc_press
	import bpc_pkg::*;
(
	input  wire logic clk,
	input  wire ctl_t ctl,
	input  wire mid_t mid,
	output out_word_t out_data
);

	// Stage 7: the 24 by 40 bit product as two partial products.
	logic [43:0]        plo_s7;
	logic signed [44:0] phi_s7;
	logic [39:0]        off_s7;
	logic [18:0]        tout_s7;

	always_ff @(posedge clk) begin
		if (ctl.en[STG_PART]) begin
			plo_s7  <= mid.raw_pressure * mid.sensitivity[19:0];
			phi_s7  <= $signed({1'b0, mid.raw_pressure}) * $signed(mid.sensitivity[39:20]);
			off_s7  <= mid.offset;
			tout_s7 <= mid.temperature;
		end
	end

	// Stage 8: recombine; the full product always fits in 64 bits.
	logic [63:0] prod_s8;
	logic [39:0] off_s8;
	logic [18:0] tout_s8;

	always_ff @(posedge clk) begin
		if (ctl.en[STG_SUM]) begin
			prod_s8 <= {phi_s7[43:0], 20'h00000} + {20'h00000, plo_s7};
			off_s8  <= off_s7;
			tout_s8 <= tout_s7;
		end
	end

	// Stage 9: scale, remove the offset, scale again and keep the low 32 bits.
	logic [43:0] diff_c;

	assign diff_c = {prod_s8[63], prod_s8[63:21]} - {{4{off_s8[39]}}, off_s8};

	out_word_t out_s9;

	always_ff @(posedge clk) begin
		if (ctl.en[STG_OUT]) begin
			out_s9.temperature <= tout_s8;
			out_s9.pressure    <= {{3{diff_c[43]}}, diff_c[43:15]};
		end
	end

	assign out_data = out_s9;

endmodule

`default_nettype wire

### design/baro_pressure_temp_compensation.sv
// Second-order barometric pressure and temperature compensation.
// Input channel (in_valid, in_ready, in_data) carries one word holding a raw
// 24-bit pressure and temperature conversion. Output channel (out_valid,
// out_ready, out_data) returns one word per input: temperature in hundredths
// of a degree and the compensated pressure, both two's complement.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// the six 16-bit calibration words, index 0 to 5; other indexes are dropped.
// cfg_ready is always high. Calibration must only change while the pipeline
// is empty.
// A new word is accepted every cycle unless the output is stalled and every
// stage holds a word. The depth is set by the 9-stage pipeline, whose
// widest multiplier is 25 by 25 bits.
// Reset clears the calibration words to zero and empties the pipeline.
// When the receiver stalls, the output word holds and empty stages ahead of it
// keep filling; in_ready drops only once every stage holds a word.
`default_nettype none

module baro_pressure_temp_compensation
	import bpc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_word_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_word_t                 out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data
);

	cal_t cal;
	ctl_t ctl;
	mid_t mid;

	// Calibration register file.
	bpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cal       (cal)
	);

	// Valid bits and stage enables.
	bpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	// Temperature and first and second order terms.
	bpc_core u_core (
		.clk     (clk),
		.cal     (cal),
		.ctl     (ctl),
		.in_data (in_data),
		.mid     (mid)
	);

	// Pressure product and output register.
	bpc_press u_press (
		.clk      (clk),
		.ctl      (ctl),
		.mid      (mid),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

### bench/baro_pressure_temp_compensation_test.sv
`timescale 1ns / 100ps

module baro_pressure_temp_compensation_test;
	import bpc_pkg::*;

	// Register indexes past the last calibration word; writes to them are dropped.
	localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_HI = 3'd7;

	// Temperature thresholds in hundredths of a degree.
	localparam longint WARM_LIMIT = 2000;
	localparam longint COLD_LIMIT = -1500;

	localparam longint RAW_MAX          = 24'hFFFFFF;
	localparam int     RANDOM_PHASES    = 6;
	localparam int     ITEMS_PER_PHASE  = 175;
	localparam int     HOLD_AT          = 60;
	localparam int     LONG_HOLD_CYCLES = 200;
	localparam int     SETTLE_CYCLES    = NUM_STAGES + 4;
	localparam int     DRAIN_LIMIT      = 20000;

	typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	// One directed step: either a calibration write or a conversion pair, the latter
	// with an optional typed-in result.
	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] index;
		logic [15:0]          value;
		logic [23:0]          raw_pressure;
		logic [23:0]          raw_temperature;
		bit                   typed;
		int                   temperature;
		int                   pressure;
	} directed_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_word_t             in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_word_t            out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	cal_t      cal_shadow;
	out_word_t pending_readings[$];
	int        mismatch_count = 0;
	int        tx_idle_pct = 27;
	int        rx_idle_pct = 85;
	bit        hold_request = 1'b0;

	// With all words zero every pair yields 20.00 degrees and zero pressure. The
	// threshold set uses reference and coefficient words of 0x8000, so that
	// TEMP = 2000 + ((raw_temperature - 2^23) >>> 8) and each threshold is hit exactly.
	directed_row_t directed_rows [0:37] = '{
		'{ROW_SAMPLE, '0, 16'h0000, 24'h000000, 24'h000000, 1'b1, 2000, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 2000, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'hAAAAAA, 24'h555555, 1'b1, 2000, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'h555555, 24'hAAAAAA, 1'b1, 2000, 0},
		'{ROW_WRITE, SPARE_INDEX_LO, 16'hFFFF, 24'h0, 24'h0, 1'b0, 0, 0},
		'{ROW_WRITE, SPARE_INDEX_HI, 16'hFFFF, 24'h0, 24'h0, 1'b0, 0, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'h123456, 24'h800000, 1'b1, 2000, 0},
		'{ROW_WRITE, REG_PRESSURE_SENSITIVITY, 16'd40127, 24'h0, 24'h0, 1'b0, 0, 0},
		'{ROW_WRITE, REG_PRESSURE_OFFSET, 16'd36924, 24'h0, 24'h0, 1'b0, 0, 0},
		'{ROW_WRITE, REG_SENSITIVITY_TEMP_COEFF, 16'd23317, 24'h0, 24'h0, 1'b0, 0, 0},
		'{ROW_WRITE, REG_OFFSET_TEMP_COEFF, 16'd23282, 24'h0, 24'h0, 1'b0, 0, 0},
		'{ROW_WRITE, REG_REFERENCE_TEMPERATURE, 16'h8000, 24'h0, 24'h0, 1'b0, 0, 0},
		'{ROW_WRITE, REG_TEMPERATURE_COEFF, 16'h8000, 24'h0, 24'h0, 1'b0, 0, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'd9085466, 24'd8388608, 1'b0, 0, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'd9085466, 24'd8388607, 1'b0, 0, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'd9085466, 24'd7492608, 1'b0, 0, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'd9085466, 24'd7492607, 1'b0, 0, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'd9085466, 24'h000000, 1'b0, 0, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'd9085466, 24'hFFFFFF, 1'b0, 0, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'h000000, 24'd8000000, 1'b0, 0, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'hFFFFFF, 24'd100, 1'b0, 0, 0},
		'{ROW_WRITE, REG_PRESSURE_SENSITIVITY, 16'hFFFF, 24'h0, 24'h0, 1'b0, 0, 0},
		'{ROW_WRITE, REG_PRESSURE_OFFSET, 16'hFFFF, 24'h0, 24'h0, 1'b0, 0, 0},
		'{ROW_WRITE, REG_SENSITIVITY_TEMP_COEFF, 16'hFFFF, 24'h0, 24'h0, 1'b0, 0, 0},
		'{ROW_WRITE, REG_OFFSET_TEMP_COEFF, 16'hFFFF, 24'h0, 24'h0, 1'b0, 0, 0},
		'{ROW_WRITE, REG_REFERENCE_TEMPERATURE, 16'hFFFF, 24'h0, 24'h0, 1'b0, 0, 0},
		'{ROW_WRITE, REG_TEMPERATURE_COEFF, 16'hFFFF, 24'h0, 24'h0, 1'b0, 0, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 0, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'hFFFFFF, 24'h000000, 1'b0, 0, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'h000000, 24'h000000, 1'b0, 0, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'h000000, 24'hFFFFFF, 1'b0, 0, 0},
		'{ROW_WRITE, REG_PRESSURE_SENSITIVITY, 16'h0000, 24'h0, 24'h0, 1'b0, 0, 0},
		'{ROW_WRITE, REG_PRESSURE_OFFSET, 16'h0000, 24'h0, 24'h0, 1'b0, 0, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'hFFFFFF, 24'h000000, 1'b0, 0, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'hFFFFFF, 24'h7FFFFF, 1'b0, 0, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'hFFFFFF, 24'hFFFF00, 1'b0, 0, 0},
		'{ROW_WRITE, SPARE_INDEX_HI, 16'h0000, 24'h0, 24'h0, 1'b0, 0, 0},
		'{ROW_SAMPLE, '0, 16'h0000, 24'h800000, 24'hFFFF00, 1'b0, 0, 0}
	};

	baro_pressure_temp_compensation i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Second-order compensation of one conversion pair with the given calibration.
	// All intermediates are signed 64-bit; >>> rounds toward minus infinity.
	function automatic out_word_t compensate(input in_word_t w, input cal_t c);
		longint d1, d2, dt, temp, off, sens, t2, off2, sens2, x, sq, pres, t_out;
		out_word_t r;
		d1 = longint'(w.raw_pressure);
		d2 = longint'(w.raw_temperature);
		dt = d2 - longint'(c.reference_temperature) * 256;
		temp = WARM_LIMIT + ((dt * longint'(c.temperature_coeff)) >>> 23);
		off = longint'(c.pressure_offset) * 65536
			+ ((longint'(c.offset_temp_coeff) * dt) >>> 7);
		sens = longint'(c.pressure_sensitivity) * 32768
			+ ((longint'(c.sensitivity_temp_coeff) * dt) >>> 8);
		t2 = 0;
		off2 = 0;
		sens2 = 0;
		// Both thresholds look at TEMP before T2 comes off it.
		if (temp < WARM_LIMIT) begin
			x = temp - WARM_LIMIT;
			sq = x * x;
			t2 = (dt * dt) >>> 31;
			off2 = (5 * sq) >>> 1;
			sens2 = (5 * sq) >>> 2;
			if (temp < COLD_LIMIT) begin
				x = temp - COLD_LIMIT;
				sq = x * x;
				off2 = off2 + 7 * sq;
				sens2 = sens2 + ((11 * sq) >>> 1);
			end
		end
		off = off - off2;
		sens = sens - sens2;
		pres = (((d1 * sens) >>> 21) - off) >>> 15;
		t_out = temp - t2;
		// The pressure keeps its low 32 bits only.
		r.temperature = t_out[18:0];
		r.pressure = pres[31:0];
		return r;
	endfunction

	// Calibration words for a random phase: one realistic set, one all-ones set,
	// the rest random with zero and all-ones words mixed in.
	function automatic logic [15:0] random_cal_word();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic cal_t calibration_for_phase(input int ph);
		cal_t c;
		if (ph == 0) begin
			c.pressure_sensitivity = 16'd40127;
			c.pressure_offset = 16'd36924;
			c.sensitivity_temp_coeff = 16'd23317;
			c.offset_temp_coeff = 16'd23282;
			c.reference_temperature = 16'd33464;
			c.temperature_coeff = 16'd28312;
		end else if (ph == 3) begin
			c = '1;
		end else begin
			c.pressure_sensitivity = random_cal_word();
			c.pressure_offset = random_cal_word();
			c.sensitivity_temp_coeff = random_cal_word();
			c.offset_temp_coeff = random_cal_word();
			c.reference_temperature = random_cal_word();
			c.temperature_coeff = random_cal_word();
		end
		return c;
	endfunction

	// Random pair; the temperature conversion mostly lands near the reference so that
	// all three temperature bands and their edges are reached.
	function automatic in_word_t random_reading();
		in_word_t w;
		int unsigned pick;
		longint center, t;
		case ($urandom_range(9))
			0: w.raw_pressure = '0;
			1: w.raw_pressure = '1;
			default: w.raw_pressure = 24'($urandom);
		endcase
		pick = $urandom_range(9);
		center = longint'(cal_shadow.reference_temperature) * 256;
		if (pick < 4)
			t = longint'($urandom_range(24'hFFFFFF));
		else if (pick < 8)
			t = center + longint'($urandom_range(1 << 22)) - (1 << 21);
		else
			t = center + longint'($urandom_range(1 << 13)) - (1 << 12);
		if (t < 0)
			t = 0;
		if (t > RAW_MAX)
			t = RAW_MAX;
		w.raw_temperature = t[23:0];
		return w;
	endfunction

	// Write one calibration register and mirror it; valid drops for a cycle after.
	task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PRESSURE_SENSITIVITY:   cal_shadow.pressure_sensitivity = value;
			REG_PRESSURE_OFFSET:        cal_shadow.pressure_offset = value;
			REG_SENSITIVITY_TEMP_COEFF: cal_shadow.sensitivity_temp_coeff = value;
			REG_OFFSET_TEMP_COEFF:      cal_shadow.offset_temp_coeff = value;
			REG_REFERENCE_TEMPERATURE:  cal_shadow.reference_temperature = value;
			REG_TEMPERATURE_COEFF:      cal_shadow.temperature_coeff = value;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one word after a random gap; its result is predicted once it is taken.
	task automatic offer_reading(input in_word_t w, input bit typed, input out_word_t typed_word);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		pending_readings.push_back(typed ? typed_word : compensate(w, cal_shadow));
	endtask

	// Let the pipeline empty before calibration changes.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver: random stalls, and a long hold-off on request so the pipeline fills.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Compare every returned word with the oldest prediction.
	always @(posedge clk) begin : check_output
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_readings.size() == 0) begin
				$error("result word with nothing outstanding: temperature %0d, pressure %0d",
					out_data.temperature, out_data.pressure);
				mismatch_count++;
			end else begin
				want = pending_readings.pop_front();
				if (out_data.temperature !== want.temperature) begin
					$error("temperature: expected %0d, actual %0d",
						want.temperature, out_data.temperature);
					mismatch_count++;
				end
				if (out_data.pressure !== want.pressure) begin
					$error("pressure: expected %0d, actual %0d",
						want.pressure, out_data.pressure);
					mismatch_count++;
				end
			end
		end
	end

	// Main sequence: reset, directed table, random phases, drain.
	initial begin
		in_word_t  w;
		out_word_t typed_word;
		cal_t      next_cal;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cal_shadow = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n]) begin
			if (directed_rows[n].kind == ROW_WRITE) begin
				wait_idle();
				write_cal(directed_rows[n].index, directed_rows[n].value);
			end else begin
				w.raw_pressure = directed_rows[n].raw_pressure;
				w.raw_temperature = directed_rows[n].raw_temperature;
				typed_word.temperature = directed_rows[n].temperature[18:0];
				typed_word.pressure = directed_rows[n].pressure;
				offer_reading(w, directed_rows[n].typed, typed_word);
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			case (ph / 2)
				0: begin
					tx_idle_pct = 27;
					rx_idle_pct = 85;
				end
				1: begin
					tx_idle_pct = 85;
					rx_idle_pct = 27;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			next_cal = calibration_for_phase(ph);
			write_cal(REG_PRESSURE_SENSITIVITY, next_cal.pressure_sensitivity);
			write_cal(REG_PRESSURE_OFFSET, next_cal.pressure_offset);
			write_cal(REG_SENSITIVITY_TEMP_COEFF, next_cal.sensitivity_temp_coeff);
			write_cal(REG_OFFSET_TEMP_COEFF, next_cal.offset_temp_coeff);
			write_cal(REG_REFERENCE_TEMPERATURE, next_cal.reference_temperature);
			write_cal(REG_TEMPERATURE_COEFF, next_cal.temperature_coeff);
			write_cal($urandom_range(1) ? SPARE_INDEX_HI : SPARE_INDEX_LO, 16'($urandom));
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (k == HOLD_AT)
					hold_request = 1'b1;
				offer_reading(random_reading(), 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		for (int n = 0; n < DRAIN_LIMIT && pending_readings.size() != 0; n++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_readings.size() != 0) begin
			$error("%0d result words never arrived", pending_readings.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#2ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
design/bpc_pkg.sv
design/bpc_cfg.sv
design/bpc_ctrl.sv
design/bpc_core.sv
design/bpc_press.sv
design/baro_pressure_temp_compensation.sv
bench/baro_pressure_temp_compensation_test.sv
